// ----- rtl/fbltc_pkg.sv -----
// Package for the four-band luma tone curve: payload structs, fixed-point
// constants and pipeline stage counts. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fbltc_pkg;

	localparam int FRAC  = 15;
	localparam int NBAND = 4;
	localparam int NLANE = NBAND + 1;

	localparam logic [15:0] ONE  = 16'(1 << FRAC);
	localparam logic [15:0] HALF = 16'(1 << (FRAC - 1));

	localparam logic [15:0] LUMA_R         = 16'd6966;
	localparam logic [15:0] LUMA_G         = 16'd23436;
	localparam logic [15:0] LUMA_B         = 16'd2366;
	localparam logic [15:0] SHADOW_FLOOR   = 16'd1475;
	localparam logic [15:0] GAIN_SHADOW    = 16'd5243;
	localparam logic [15:0] GAIN_DARK      = 16'd5079;
	localparam logic [15:0] GAIN_LIGHT     = 16'd5407;
	localparam logic [15:0] GAIN_HIGHLIGHT = 16'd4915;
	localparam int          STRENGTH_SHIFT = FRAC - 2;

	localparam logic [2:0] CFG_EDGES_BASE = 3'd4;

	localparam int LUMA_STAGES  = 2;
	localparam int DIV_STEP     = 3;
	localparam int DIV_STAGES   = (FRAC + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV_PIPE     = DIV_STAGES + 1;
	localparam int CURVE_STAGES = 4;
	localparam int MIX_STAGES   = 3;
	localparam int DIV_BASE     = LUMA_STAGES;
	localparam int CURVE_BASE   = DIV_BASE + DIV_PIPE;
	localparam int MIX_BASE     = CURVE_BASE + CURVE_STAGES;
	localparam int NSTAGE       = MIX_BASE + MIX_STAGES;

	typedef struct packed {
		logic [15:0] red_in;
		logic [15:0] green_in;
		logic [15:0] blue_in;
		logic [15:0] alpha_in;
	} pix_in_t;

	typedef struct packed {
		logic [15:0] red_out;
		logic [15:0] green_out;
		logic [15:0] blue_out;
		logic [15:0] alpha_out;
	} pix_out_t;

	typedef struct packed {
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
		logic [15:0] alpha;
		logic [15:0] y;
	} side_t;

	function automatic logic [15:0] clamp_one(input logic [15:0] v);
		return (v > ONE) ? ONE : v;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/four_band_luma_tone_curve_top.sv -----
// Four-band luma tone curve, top level: config registers, stage valids and
// the ready chain. Depends on fbltc_pkg and the fbltc_* stage modules.
//
// Usage. Pixels enter on in_valid/in_ready/in_data and results leave on
// out_valid/out_ready/out_data, one result per pixel, in order. Each channel
// accepts an item at a clock edge where its valid and ready are both high.
// The pipeline has 15 register stages: 2 for clamp and luma, 6 for the ramp
// divider (setup plus 5 stages of 3 quotient bits), 4 for the smoothstep
// polynomial, masks and gains, 3 for weighting and apply.
// Throughput is one pixel per clock while the output is not stalled; the
// divider pipeline is the deepest section.
// Each stage holds its item while the next is full and stalled, so a
// stalled receiver fills the bubbles first and then backs up to in_ready;
// nothing is dropped or repeated.
// Write registers through cfg_we/cfg_index/cfg_data (0-3 strengths, 4-7 band
// edges) only while the pipeline is empty; the block does not enforce this.
// Reset (arst_n low) zeroes config and valid flops and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module four_band_luma_tone_curve_top (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  fbltc_pkg::pix_in_t   in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output fbltc_pkg::pix_out_t  out_data,
	input  wire                  cfg_we,
	input  wire  [2:0]           cfg_index,
	input  wire  [31:0]          cfg_data
);
	import fbltc_pkg::*;

	logic [NBAND-1:0][15:0] strength_q;
	logic [NBAND-1:0][31:0] edges_q;
	logic [NSTAGE-1:0]      vld_q;
	logic [NSTAGE-1:0]      en;

	side_t                  side_l, side_d, side_c;
	logic [NLANE-1:0][15:0] t;
	logic [NBAND-1:0][15:0] gain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q <= '0;
			edges_q    <= '0;
		end else if (cfg_we) begin
			if (cfg_index < CFG_EDGES_BASE)
				strength_q[cfg_index[1:0]] <= cfg_data[15:0];
			else
				edges_q[cfg_index[1:0]] <= cfg_data;
		end
	end

	always_comb begin
		en[NSTAGE-1] = !vld_q[NSTAGE-1] || out_ready;
		for (int k = NSTAGE - 2; k >= 0; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < NSTAGE; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[NSTAGE-1];

	fbltc_luma u_luma (
		.clk  (clk),
		.en   (en[LUMA_STAGES-1:0]),
		.pix  (in_data),
		.side (side_l)
	);

	fbltc_div u_div (
		.clk      (clk),
		.en       (en[CURVE_BASE-1:DIV_BASE]),
		.edges    (edges_q),
		.side_in  (side_l),
		.side_out (side_d),
		.t        (t)
	);

	fbltc_curve u_curve (
		.clk      (clk),
		.en       (en[MIX_BASE-1:CURVE_BASE]),
		.t        (t),
		.side_in  (side_d),
		.side_out (side_c),
		.gain     (gain)
	);

	fbltc_mix u_mix (
		.clk      (clk),
		.en       (en[NSTAGE-1:MIX_BASE]),
		.strength (strength_q),
		.gain     (gain),
		.side_in  (side_c),
		.pix      (out_data)
	);

`ifndef SYNTHESIS
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.red_out <= ONE) && (out_data.green_out <= ONE)
			&& (out_data.blue_out <= ONE))
		else $error("color result above one");

	a_empty_tail_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[NSTAGE-1] |-> in_ready)
		else $error("not ready with empty output stage");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted item missing from first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] && !en[1] |=> vld_q[0] && $stable(u_luma.side_s1))
		else $error("first stage item lost under stall");
`endif
endmodule
`default_nettype wire

// ----- rtl/fbltc_luma.sv -----
// Input clamp and Rec.709 luma, two pipeline stages.
// Depends on fbltc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fbltc_luma (
	input  wire                   clk,
	input  wire  [1:0]            en,
	input  fbltc_pkg::pix_in_t    pix,
	output fbltc_pkg::side_t      side
);
	import fbltc_pkg::*;

	side_t       side_s1, side_s2;
	logic [31:0] ysum;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_s1.r     <= clamp_one(pix.red_in);
			side_s1.g     <= clamp_one(pix.green_in);
			side_s1.b     <= clamp_one(pix.blue_in);
			side_s1.alpha <= pix.alpha_in;
			side_s1.y     <= '0;
		end
	end

	assign ysum = 32'(LUMA_R) * 32'(side_s1.r) + 32'(LUMA_G) * 32'(side_s1.g)
		+ 32'(LUMA_B) * 32'(side_s1.b) + 32'(HALF);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			side_s2.r     <= side_s1.r;
			side_s2.g     <= side_s1.g;
			side_s2.b     <= side_s1.b;
			side_s2.alpha <= side_s1.alpha;
			side_s2.y     <= ysum[FRAC+15:FRAC];
		end
	end

	assign side = side_s2;
endmodule
`default_nettype wire

// ----- rtl/fbltc_div.sv -----
// Smoothstep ramp t = (v - lo) / (hi - lo) for the four bands and the shadow
// floor: setup stage, then a pipelined restoring divider. Depends on fbltc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fbltc_div (
	input  wire                                  clk,
	input  wire  [fbltc_pkg::DIV_PIPE-1:0]       en,
	input  wire  [fbltc_pkg::NBAND-1:0][31:0]    edges,
	input  fbltc_pkg::side_t                     side_in,
	output fbltc_pkg::side_t                     side_out,
	output logic [fbltc_pkg::NLANE-1:0][15:0]    t
);
	import fbltc_pkg::*;

	typedef struct packed {
		logic            fixed;
		logic [15:0]     tfix;
		logic [15:0]     den;
		logic [15:0]     rem;
		logic [FRAC-1:0] low;
		logic [FRAC-1:0] q;
	} lane_t;

	function automatic lane_t div_step(input lane_t l, input int nb);
		lane_t       o;
		logic [16:0] tr;
		o = l;
		for (int j = 0; j < DIV_STEP; j++) begin
			if (j < nb) begin
				tr    = {o.rem, o.low[FRAC-1]};
				o.low = {o.low[FRAC-2:0], 1'b0};
				if (tr >= {1'b0, o.den}) begin
					tr  = tr - {1'b0, o.den};
					o.q = {o.q[FRAC-2:0], 1'b1};
				end else begin
					o.q = {o.q[FRAC-2:0], 1'b0};
				end
				o.rem = tr[15:0];
			end
		end
		return o;
	endfunction

	lane_t [NLANE-1:0] lane_s [DIV_PIPE];
	side_t             side_s [DIV_PIPE];
	lane_t [NLANE-1:0] setup;

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			logic [15:0]        lo, hi;
			logic signed [17:0] num, den;
			if (i < NBAND) begin
				lo = edges[i][15:0];
				hi = edges[i][31:16];
			end else begin
				lo = '0;
				hi = SHADOW_FLOOR;
			end
			num = $signed({2'b00, side_in.y}) - $signed({2'b00, lo});
			den = $signed({2'b00, hi}) - $signed({2'b00, lo});
			if (den < 0) begin
				den = -den;
				num = -num;
			end
			setup[i].den  = den[15:0];
			setup[i].rem  = num[15:0];
			setup[i].low  = den[15:1];
			setup[i].q    = '0;
			setup[i].fixed = 1'b1;
			if (lo == hi) begin
				setup[i].tfix = (side_in.y < lo) ? 16'd0 : ONE;
			end else if (num <= 0) begin
				setup[i].tfix = 16'd0;
			end else if (num >= den) begin
				setup[i].tfix = ONE;
			end else begin
				setup[i].tfix  = 16'd0;
				setup[i].fixed = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			lane_s[0] <= setup;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k < DIV_PIPE; k++) begin : g_step
		localparam int NB = (FRAC - (k - 1) * DIV_STEP < DIV_STEP)
			? FRAC - (k - 1) * DIV_STEP : DIV_STEP;
		always_ff @(posedge clk) begin
			if (en[k]) begin
				for (int i = 0; i < NLANE; i++)
					lane_s[k][i] <= div_step(lane_s[k-1][i], NB);
				side_s[k] <= side_s[k-1];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NLANE; i++)
			t[i] = lane_s[DIV_PIPE-1][i].fixed ? lane_s[DIV_PIPE-1][i].tfix
				: {1'b0, lane_s[DIV_PIPE-1][i].q};
	end

	assign side_out = side_s[DIV_PIPE-1];
endmodule
`default_nettype wire

// ----- rtl/fbltc_curve.sv -----
// Smoothstep polynomial, band masks and band gains, four pipeline stages.
// Depends on fbltc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fbltc_curve (
	input  wire                                  clk,
	input  wire  [fbltc_pkg::CURVE_STAGES-1:0]   en,
	input  wire  [fbltc_pkg::NLANE-1:0][15:0]    t,
	input  fbltc_pkg::side_t                     side_in,
	output fbltc_pkg::side_t                     side_out,
	output logic [fbltc_pkg::NBAND-1:0][15:0]    gain
);
	import fbltc_pkg::*;

	logic [NLANE-1:0][15:0] t_s1, t2_s1, s_s2;
	logic [NBAND-1:0][15:0] m_s3, g_s4;
	side_t                  side_s1, side_s2, side_s3, side_s4;

	function automatic logic [15:0] rmul(input logic [15:0] a, input logic [15:0] b);
		logic [31:0] p;
		p = 32'(a) * 32'(b) + 32'(HALF);
		return p[FRAC+15:FRAC];
	endfunction

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < NLANE; i++) begin
				t_s1[i]  <= t[i];
				t2_s1[i] <= rmul(t[i], t[i]);
			end
			side_s1 <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < NLANE; i++) begin
				logic [16:0] fac;
				logic [33:0] p;
				fac = 17'(3 * (1 << FRAC)) - {t_s1[i], 1'b0};
				p   = 34'(t2_s1[i]) * 34'(fac) + 34'(HALF);
				s_s2[i] <= (p[33:FRAC] > 19'(ONE)) ? ONE : p[FRAC+15:FRAC];
			end
			side_s2 <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			m_s3[0] <= rmul(ONE - s_s2[0], s_s2[NBAND]);
			m_s3[1] <= rmul(s_s2[0], ONE - s_s2[1]);
			m_s3[2] <= rmul(s_s2[1], ONE - s_s2[2]);
			m_s3[3] <= s_s2[3];
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			g_s4[0] <= rmul(GAIN_SHADOW, m_s3[0]);
			g_s4[1] <= rmul(GAIN_DARK, m_s3[1]);
			g_s4[2] <= rmul(GAIN_LIGHT, m_s3[2]);
			g_s4[3] <= rmul(GAIN_HIGHLIGHT, m_s3[3]);
			side_s4 <= side_s3;
		end
	end

	assign gain     = g_s4;
	assign side_out = side_s4;
endmodule
`default_nettype wire

// ----- rtl/fbltc_mix.sv -----
// Strength weighting, luma shift and color apply; last stage is the output
// register. Depends on fbltc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fbltc_mix (
	input  wire                                  clk,
	input  wire  [fbltc_pkg::MIX_STAGES-1:0]     en,
	input  wire  [fbltc_pkg::NBAND-1:0][15:0]    strength,
	input  wire  [fbltc_pkg::NBAND-1:0][15:0]    gain,
	input  fbltc_pkg::side_t                     side_in,
	output fbltc_pkg::pix_out_t                  pix
);
	import fbltc_pkg::*;

	logic signed [NBAND-1:0][31:0] p_s1;
	logic signed [17:0]            ld_s2;
	side_t                         side_s1, side_s2;
	pix_out_t                      pix_s3;

	logic signed [33:0] acc;
	logic        [33:0] mag;
	logic        [20:0] magr;
	logic signed [21:0] delta, tgt;
	logic        [15:0] tclamp;

	function automatic logic [15:0] clamp_sum(input logic [15:0] c, input logic signed [17:0] d);
		logic signed [18:0] s;
		s = $signed({3'b000, c}) + 19'(d);
		if (s < 0) return 16'd0;
		if (s > $signed({3'b000, ONE})) return ONE;
		return s[15:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < NBAND; i++) begin
				logic signed [32:0] p;
				p = $signed(strength[i]) * $signed({1'b0, gain[i]});
				p_s1[i] <= p[31:0];
			end
			side_s1 <= side_in;
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NBAND; i++)
			acc = acc + 34'($signed(p_s1[i]));
		mag   = (acc < 0) ? 34'(-acc) : 34'(acc);
		magr  = 21'((mag + 34'(1 << (STRENGTH_SHIFT - 1))) >> STRENGTH_SHIFT);
		delta = (acc < 0) ? -$signed({1'b0, magr}) : $signed({1'b0, magr});
		tgt   = $signed({6'b0, side_s1.y}) + delta;
		if (tgt < 0)
			tclamp = 16'd0;
		else if (tgt > $signed({6'b0, ONE}))
			tclamp = ONE;
		else
			tclamp = tgt[15:0];
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ld_s2   <= $signed({2'b00, tclamp}) - $signed({2'b00, side_s1.y});
			side_s2 <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pix_s3.red_out   <= clamp_sum(side_s2.r, ld_s2);
			pix_s3.green_out <= clamp_sum(side_s2.g, ld_s2);
			pix_s3.blue_out  <= clamp_sum(side_s2.b, ld_s2);
			pix_s3.alpha_out <= side_s2.alpha;
		end
	end

	assign pix = pix_s3;
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for four_band_luma_tone_curve_top: directed and random pixels
// through the valid/ready channels, checked against an in-bench predictor.
// Depends on fbltc_pkg and the RTL top level.
`timescale 1ns / 1ps
module tb;
	import fbltc_pkg::*;

	localparam int ONEI = 32768;
	localparam int LATENCY = 15;
	localparam int WATCHDOG = 2000;

	typedef enum logic [2:0] {
		REG_SH_STR, REG_DK_STR, REG_LT_STR, REG_HL_STR,
		REG_SH_EDG, REG_DK_EDG, REG_LT_EDG, REG_HL_EDG
	} reg_idx_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pix_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pix_out_t out_data;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	four_band_luma_tone_curve_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	logic signed [15:0] strength_q [4];
	logic [31:0] edges_q [4];
	pix_in_t pixel_queue [$];
	pix_out_t expected_pixels [$];
	int errors = 0;
	int pixels_sent = 0;
	int pixels_checked = 0;
	bit calm = 1'b0;
	int in_gap = 0;
	int out_stall = 0;
	int idle_cycles = 0;

	function automatic longint rnd_q(longint p);
		return (p + 16384) >>> 15;
	endfunction

	function automatic longint clip_one(longint v);
		if (v < 0) return 0;
		if (v > ONEI) return ONEI;
		return v;
	endfunction

	function automatic longint smoothstep(longint lo, longint hi, longint v);
		longint num, den, t, t2;
		if (lo == hi) return (v < lo) ? 0 : ONEI;
		num = v - lo;
		den = hi - lo;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		if (num <= 0) t = 0;
		else if (num >= den) t = ONEI;
		else t = (num * ONEI + den / 2) / den;
		t2 = rnd_q(t * t);
		return clip_one(rnd_q(t2 * (3 * ONEI - 2 * t)));
	endfunction

	function automatic longint band_curve(int b, longint y);
		return smoothstep(longint'(edges_q[b][15:0]), longint'(edges_q[b][31:16]), y);
	endfunction

	function automatic pix_out_t tone_map(pix_in_t p);
		pix_out_t o;
		longint r, g, b, y, s0, s1, s2, s3, m0, m1, m2, acc, mag, delta, ld;
		r = clip_one(longint'(p.red_in));
		g = clip_one(longint'(p.green_in));
		b = clip_one(longint'(p.blue_in));
		y = rnd_q(longint'(LUMA_R) * r + longint'(LUMA_G) * g + longint'(LUMA_B) * b);
		s0 = band_curve(0, y);
		s1 = band_curve(1, y);
		s2 = band_curve(2, y);
		s3 = band_curve(3, y);
		m0 = rnd_q((ONEI - s0) * smoothstep(0, longint'(SHADOW_FLOOR), y));
		m1 = rnd_q(s0 * (ONEI - s1));
		m2 = rnd_q(s1 * (ONEI - s2));
		acc = longint'(strength_q[0]) * rnd_q(longint'(GAIN_SHADOW) * m0)
			+ longint'(strength_q[1]) * rnd_q(longint'(GAIN_DARK) * m1)
			+ longint'(strength_q[2]) * rnd_q(longint'(GAIN_LIGHT) * m2)
			+ longint'(strength_q[3]) * rnd_q(longint'(GAIN_HIGHLIGHT) * s3);
		mag = (acc < 0) ? -acc : acc;
		mag = (mag + (1 << (STRENGTH_SHIFT - 1))) >>> STRENGTH_SHIFT;
		delta = (acc < 0) ? -mag : mag;
		ld = clip_one(y + delta) - y;
		o.red_out = 16'(clip_one(r + ld));
		o.green_out = 16'(clip_one(g + ld));
		o.blue_out = 16'(clip_one(b + ld));
		o.alpha_out = p.alpha_in;
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("tb: mismatch %s got %0d want %0d", what, got, want);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_pixels.push_back(tone_map(in_data));
				pixels_sent++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pixel_queue.size() > 0) begin
					in_data <= pixel_queue.pop_front();
					in_valid <= 1'b1;
					if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		pix_out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				pixels_checked++;
				if (expected_pixels.size() == 0) begin
					report_mismatch("unexpected item", 0, 0);
				end else begin
					want = expected_pixels.pop_front();
					if (out_data.red_out != want.red_out)
						report_mismatch("red", out_data.red_out, want.red_out);
					if (out_data.green_out != want.green_out)
						report_mismatch("green", out_data.green_out, want.green_out);
					if (out_data.blue_out != want.blue_out)
						report_mismatch("blue", out_data.blue_out, want.blue_out);
					if (out_data.alpha_out != want.alpha_out)
						report_mismatch("alpha", out_data.alpha_out, want.alpha_out);
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0) out_stall = $urandom_range(1, 3);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("tb: timeout");
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	task automatic write_reg(reg_idx_e idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < REG_SH_EDG) strength_q[idx] = val[15:0];
		else edges_q[idx - REG_SH_EDG] = val;
	endtask

	task automatic drain;
		wait (pixel_queue.size() == 0 && !in_valid && expected_pixels.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [15:0] rnd_chan();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'd32768;
			2: return 16'($urandom_range(0, 65535));
			3: return 16'($urandom_range(0, 3000));
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic [15:0] rnd_edge();
		case ($urandom_range(0, 6))
			0: return 16'd0;
			1: return 16'd32768;
			2: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic [15:0] rnd_strength();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic push_pixel(logic [15:0] r, g, b, a);
		pix_in_t p;
		p.red_in = r;
		p.green_in = g;
		p.blue_in = b;
		p.alpha_in = a;
		pixel_queue.push_back(p);
	endtask

	initial begin
		pix_in_t p;
		for (int i = 0; i < 4; i++) begin
			strength_q[i] = '0;
			edges_q[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: typical bands, extremes of channels
		write_reg(REG_SH_STR, 32'h0000_2000);
		write_reg(REG_DK_STR, 32'h0000_e000);
		write_reg(REG_LT_STR, 32'h0000_7fff);
		write_reg(REG_HL_STR, 32'h0000_8000);
		write_reg(REG_SH_EDG, {16'd6000, 16'd1000});
		write_reg(REG_DK_EDG, {16'd16000, 16'd8000});
		write_reg(REG_LT_EDG, {16'd26000, 16'd18000});
		write_reg(REG_HL_EDG, {16'd32768, 16'd24000});
		push_pixel(16'd0, 16'd0, 16'd0, 16'd0);
		push_pixel(16'd32768, 16'd32768, 16'd32768, 16'hffff);
		push_pixel(16'hffff, 16'hffff, 16'hffff, 16'h5a5a);
		push_pixel(16'h7fff, 16'h0000, 16'hffff, 16'ha5a5);
		push_pixel(16'd1000, 16'd1000, 16'd1000, 16'd1);
		push_pixel(16'd1475, 16'd1475, 16'd1475, 16'd2);
		push_pixel(16'd12000, 16'd12000, 16'd12000, 16'd3);
		push_pixel(16'd22000, 16'd22000, 16'd22000, 16'd4);
		push_pixel(16'd30000, 16'd100, 16'd32768, 16'd5);
		drain();
		// equal edges (step), reversed edges, edges above one
		write_reg(REG_SH_EDG, {16'd4000, 16'd4000});
		write_reg(REG_DK_EDG, {16'd8000, 16'd20000});
		write_reg(REG_LT_EDG, {16'hffff, 16'd30000});
		write_reg(REG_HL_EDG, {16'd0, 16'd0});
		push_pixel(16'd3999, 16'd3999, 16'd3999, 16'd6);
		push_pixel(16'd4000, 16'd4000, 16'd4000, 16'd7);
		push_pixel(16'd14000, 16'd14000, 16'd14000, 16'd8);
		push_pixel(16'd31000, 16'd31000, 16'd31000, 16'd9);
		push_pixel(16'd0, 16'd32768, 16'd0, 16'd10);
		drain();

		// random phases
		for (int ph = 0; ph < 13; ph++) begin
			if (ph == 12) calm = 1'b1;
			for (int i = 0; i < 4; i++)
				write_reg(reg_idx_e'(i), {16'd0, rnd_strength()});
			for (int i = 0; i < 4; i++)
				write_reg(reg_idx_e'(REG_SH_EDG + i), {rnd_edge(), rnd_edge()});
			for (int n = 0; n < 150; n++) begin
				p.red_in = rnd_chan();
				p.green_in = rnd_chan();
				p.blue_in = rnd_chan();
				p.alpha_in = 16'($urandom_range(0, 65535));
				pixel_queue.push_back(p);
			end
			drain();
		end

		$display("tb: %0d pixels sent, %0d checked over 15 register settings",
			pixels_sent, pixels_checked);
		if (errors == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end

endmodule
